FILE: rtl/nfa_pattern_search_earliest_start_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef NFA_PATTERN_SEARCH_EARLIEST_START_ASSERT_SVH
`define NFA_PATTERN_SEARCH_EARLIEST_START_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define NPS_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define NPS_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

FILE: rtl/nps_pkg.sv
`default_nettype none
package nps_pkg;

    localparam int NODES_DEF    = 32;
    localparam int POS_BITS_DEF = 32;

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_FEED    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_WALK,
        ST_SCAN,
        ST_TAIL,
        ST_DONE
    } nps_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic restart;
        logic seed;       // start walk at node 0 with current position
        logic walk_step;  // one step of the running chain walk
        logic swap;       // pending set becomes active, position advances
        logic scan_step;  // test one active node, maybe start a walk
        logic capture;    // latch the text character of the item
    } nps_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic walk_busy;
        logic scan_last;
    } nps_status_t;

endpackage
`default_nettype wire

FILE: rtl/nps_ctrl.sv
`default_nettype none
module nps_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         operation,
    output logic                    out_valid,
    input  wire logic               out_stall,
    input  wire nps_pkg::nps_status_t status,
    output nps_pkg::nps_cmd_t       cmd
);
    import nps_pkg::*;

    nps_state_t state_reg, state_next;
    logic       accept;

    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (operation == OP_FEED) ? ST_SEED : ST_DONE;
                end
            end
            ST_SEED:
            begin
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (!status.walk_busy)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!status.walk_busy && status.scan_last)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                // The last scanned node may still have a walk to finish.
                if (!status.walk_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall      = 1'b0;
                cmd.capture   = accept;
                cmd.load      = accept && (operation == OP_LOAD);
                cmd.restart   = accept && (operation == OP_RESTART);
            end
            ST_SEED:
            begin
                cmd.seed = 1'b1;
            end
            ST_WALK:
            begin
                cmd.walk_step = status.walk_busy;
                cmd.swap      = !status.walk_busy;
            end
            ST_SCAN:
            begin
                cmd.walk_step = status.walk_busy;
                cmd.scan_step = !status.walk_busy;
            end
            ST_TAIL:
            begin
                cmd.walk_step = status.walk_busy;
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/nps_dp.sv
`default_nettype none
module nps_dp #(
    parameter int NODES    = nps_pkg::NODES_DEF,
    parameter int POS_BITS = nps_pkg::POS_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire nps_pkg::nps_cmd_t     cmd,
    output nps_pkg::nps_status_t       status,
    input  wire logic [31:0]           start_position,
    input  wire logic [4:0]            node_index,
    input  wire logic                  node_kind,
    input  wire logic [7:0]            node_char,
    input  wire logic [5:0]            node_successor,
    input  wire logic [5:0]            node_alternative,
    input  wire logic [7:0]            text_char,
    output logic                       match_found,
    output logic [31:0]                earliest_start,
    output logic [31:0]                current_position
);
    import nps_pkg::*;

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = $clog2(NODES + 1);

    // Node table kept in flops: it is read at the scan index and at the
    // walk pointer, and is small.
    logic             kind_reg [NODES];
    logic [7:0]       chr_reg  [NODES];
    logic [5:0]       succ_reg [NODES];
    logic [5:0]       alt_reg  [NODES];

    logic [NODES-1:0]    pvalid_reg, avalid_reg;
    logic [POS_BITS-1:0] pstart_reg [NODES];
    logic [POS_BITS-1:0] astart_reg [NODES];
    logic [POS_BITS-1:0] pos_reg;
    logic                mvalid_reg;
    logic [POS_BITS-1:0] mstart_reg;
    logic [7:0]          tchar_reg;

    // Chain walker.
    logic                walk_reg;
    logic [5:0]          widx_reg;
    logic [CW-1:0]       wcnt_reg;
    logic [POS_BITS-1:0] wstart_reg;
    // Active-set scanner.
    logic [CW-1:0]       sidx_reg;

    logic                widx_ok;
    logic [IW-1:0]       wi;
    logic                upd;
    logic [POS_BITS-1:0] eff_start;
    logic [IW-1:0]       si;
    logic                hit;

    assign widx_ok   = (32'(widx_reg) < 32'(NODES)) && (wcnt_reg < CW'(NODES));
    assign wi        = IW'(widx_reg);
    assign upd       = !pvalid_reg[wi] || (pstart_reg[wi] > wstart_reg);
    assign eff_start = upd ? wstart_reg : pstart_reg[wi];
    assign si        = sidx_reg[IW-1:0];
    assign hit       = avalid_reg[si] && !kind_reg[si] && (chr_reg[si] == tchar_reg);

    assign status.walk_busy = walk_reg && widx_ok;
    assign status.scan_last = (sidx_reg == CW'(NODES - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load && (32'(node_index) < NODES))
        begin
            kind_reg[IW'(node_index)] <= node_kind;
            chr_reg[IW'(node_index)]  <= node_char;
            succ_reg[IW'(node_index)] <= node_successor;
            alt_reg[IW'(node_index)]  <= node_alternative;
        end
        if (cmd.capture)
        begin
            tchar_reg <= text_char;
        end
        if (cmd.walk_step && upd)
        begin
            pstart_reg[wi] <= wstart_reg;
        end
        if (cmd.swap)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                astart_reg[i] <= pstart_reg[i];
            end
        end
        if (cmd.seed)
        begin
            wstart_reg <= pos_reg;
        end
        else if (cmd.scan_step)
        begin
            wstart_reg <= astart_reg[si];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= '0;
            avalid_reg <= '0;
            pos_reg    <= '0;
            mvalid_reg <= 1'b0;
            mstart_reg <= '0;
            walk_reg   <= 1'b0;
            widx_reg   <= '0;
            wcnt_reg   <= '0;
            sidx_reg   <= '0;
        end
        else
        begin
            if (cmd.restart)
            begin
                pvalid_reg <= '0;
                avalid_reg <= '0;
                mvalid_reg <= 1'b0;
                mstart_reg <= '0;
                pos_reg    <= POS_BITS'(start_position);
            end
            if (cmd.seed)
            begin
                walk_reg <= 1'b1;
                widx_reg <= '0;
                wcnt_reg <= '0;
            end
            if (cmd.walk_step)
            begin
                pvalid_reg[wi] <= 1'b1;
                if (kind_reg[wi] && (!mvalid_reg || (mstart_reg > eff_start)))
                begin
                    mvalid_reg <= 1'b1;
                    mstart_reg <= eff_start;
                end
                widx_reg <= alt_reg[wi];
                wcnt_reg <= wcnt_reg + 1'b1;
            end
            if (cmd.swap)
            begin
                avalid_reg <= pvalid_reg;
                pvalid_reg <= '0;
                pos_reg    <= pos_reg + 1'b1;
                walk_reg   <= 1'b0;
                sidx_reg   <= '0;
            end
            if (cmd.scan_step)
            begin
                sidx_reg <= status.scan_last ? '0 : sidx_reg + 1'b1;
                walk_reg <= hit;
                widx_reg <= succ_reg[si];
                wcnt_reg <= '0;
            end
        end
    end

    assign match_found      = mvalid_reg;
    assign earliest_start   = mvalid_reg ? 32'(mstart_reg) : 32'd0;
    assign current_position = 32'(pos_reg);

endmodule
`default_nettype wire

FILE: rtl/nfa_pattern_search_earliest_start.sv
`default_nettype none
// Pattern automaton search. One item at a time. Load and restart go
// straight to a result; a feed first walks the chain from node 0, makes
// the pending set active, then scans the active set one node per cycle
// while no chain walk runs, and each chain walk visits one node per cycle
// through the node table. A stalled result is held until it is taken.
`include "nfa_pattern_search_earliest_start_assert.svh"
module nfa_pattern_search_earliest_start #(
    parameter int NODES    = nps_pkg::NODES_DEF,
    parameter int POS_BITS = nps_pkg::POS_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [4:0]  node_index,
    input  wire logic        node_kind,
    input  wire logic [7:0]  node_char,
    input  wire logic [5:0]  node_successor,
    input  wire logic [5:0]  node_alternative,
    input  wire logic [7:0]  text_char,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             match_found,
    output logic [31:0]      earliest_start,
    output logic [31:0]      current_position
);
    import nps_pkg::*;

    nps_cmd_t    cmd;
    nps_status_t status;
    logic [31:0] start_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            start_reg <= cfg_data;
        end
    end

    nps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    nps_dp #(
        .NODES    (NODES),
        .POS_BITS (POS_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .start_position   (start_reg),
        .node_index       (node_index),
        .node_kind        (node_kind),
        .node_char        (node_char),
        .node_successor   (node_successor),
        .node_alternative (node_alternative),
        .text_char        (text_char),
        .match_found      (match_found),
        .earliest_start   (earliest_start),
        .current_position (current_position)
    );

    `NPS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, in_stall,
        "input taken while a result is shown")
    `NPS_ASSERT_NEXT(a_match_sticky, clk, rst_n, match_found && !cmd.restart,
        match_found, "match flag dropped without restart")
    `NPS_ASSERT_IMP(a_one_phase, clk, rst_n, 1'b1,
        $countones({cmd.seed, cmd.swap, cmd.scan_step, cmd.capture}) <= 1,
        "conflicting datapath commands")

endmodule
`default_nettype wire

FILE: tb/sv/nfa_pattern_search_earliest_start_tb.sv
`default_nettype none
module nfa_pattern_search_earliest_start_tb;
    import nps_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int N_NODES = 32;
    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [1:0] op;
        logic [4:0] idx;
        logic       kind;
        logic [7:0] chr;
        logic [5:0] succ;
        logic [5:0] alt;
        logic [7:0] tch;
        bit         typed;
        logic       e_mf;
        logic [31:0] e_es;
        logic [31:0] e_cp;
    } search_item_t;

    typedef struct {
        logic        mf;
        logic [31:0] es;
        logic [31:0] cp;
    } search_status_t;

    typedef struct {
        logic       kind;
        logic [7:0] chr;
        logic [5:0] succ;
        logic [5:0] alt;
    } node_rec_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [1:0] operation;
    logic [4:0] node_index;
    logic node_kind;
    logic [7:0] node_char;
    logic [5:0] node_successor;
    logic [5:0] node_alternative;
    logic [7:0] text_char;
    logic out_valid;
    logic out_stall;
    logic match_found;
    logic [31:0] earliest_start;
    logic [31:0] current_position;

    nfa_pattern_search_earliest_start dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .node_index(node_index), .node_kind(node_kind),
        .node_char(node_char), .node_successor(node_successor),
        .node_alternative(node_alternative), .text_char(text_char),
        .out_valid(out_valid), .out_stall(out_stall),
        .match_found(match_found), .earliest_start(earliest_start),
        .current_position(current_position)
    );

    // Predictor state.
    node_rec_t   ntab[N_NODES];
    bit          pend_v[N_NODES];
    logic [31:0] pend_s[N_NODES];
    bit          act_v[N_NODES];
    logic [31:0] act_s[N_NODES];
    logic [31:0] pos;
    bit          m_v;
    logic [31:0] m_s;
    logic [31:0] start_reg;
    bit          written[N_NODES];

    search_status_t status_q[$];
    int errors = 0;
    int idle_cnt = 0;
    int hold_cnt = 0;
    bit quiet = 0;

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic void enter_chain(int first, logic [31:0] st);
        int i;
        i = first;
        for (int steps = 0; steps < N_NODES && i < N_NODES; steps++) begin
            if (!pend_v[i] || pend_s[i] > st) begin
                pend_v[i] = 1;
                pend_s[i] = st;
            end
            if (ntab[i].kind && (!m_v || m_s > pend_s[i])) begin
                m_v = 1;
                m_s = pend_s[i];
            end
            i = ntab[i].alt;
        end
    endfunction

    function automatic void clear_sets();
        for (int i = 0; i < N_NODES; i++) begin
            pend_v[i] = 0; pend_s[i] = 0; act_v[i] = 0; act_s[i] = 0;
        end
        m_v = 0;
        m_s = 0;
    endfunction

    function automatic search_status_t search_step(search_item_t it);
        search_status_t r;
        case (it.op)
            OP_LOAD: begin
                ntab[it.idx] = '{it.kind, it.chr, it.succ, it.alt};
                written[it.idx] = 1;
            end
            OP_RESTART: begin
                clear_sets();
                pos = start_reg;
            end
            OP_FEED: begin
                enter_chain(0, pos);
                pos = pos + 1;
                for (int i = 0; i < N_NODES; i++) begin
                    act_v[i] = pend_v[i];
                    act_s[i] = pend_s[i];
                    pend_v[i] = 0;
                    pend_s[i] = 0;
                end
                for (int i = 0; i < N_NODES; i++)
                    if (act_v[i] && !ntab[i].kind && ntab[i].chr == it.tch)
                        enter_chain(ntab[i].succ, act_s[i]);
            end
            default: ;
        endcase
        r.mf = m_v;
        r.es = m_v ? m_s : 32'd0;
        r.cp = pos;
        return r;
    endfunction

    function automatic search_item_t row(logic [1:0] op, logic [4:0] idx, logic kind,
                                         logic [7:0] chr, logic [5:0] succ, logic [5:0] alt,
                                         logic [7:0] tch);
        search_item_t it;
        it = '{op, idx, kind, chr, succ, alt, tch, 0, 0, 0, 0};
        return it;
    endfunction

    function automatic search_item_t typed_row(search_item_t it, logic mf, logic [31:0] es,
                                               logic [31:0] cp);
        it.typed = 1;
        it.e_mf = mf;
        it.e_es = es;
        it.e_cp = cp;
        return it;
    endfunction

    // Link to a node already written, to the node being loaded, or to none.
    function automatic logic [5:0] pick_link(int self);
        int k;
        if ($urandom_range(0, 99) < 45)
            return 6'($urandom_range(32, 63));
        do k = $urandom_range(0, N_NODES - 1); while (!written[k] && k != self);
        return 6'(k);
    endfunction

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 99) < 85)
            return 8'($urandom_range(8'h61, 8'h63));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic search_item_t random_item();
        search_item_t it;
        int r;
        r = $urandom_range(0, 99);
        it = row(OP_FEED, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), pick_char());
        if (r < 14) begin
            it.op = OP_LOAD;
            it.kind = ($urandom_range(0, 99) < 15);
            it.chr = pick_char();
            it.succ = pick_link(it.idx);
            it.alt = pick_link(it.idx);
        end else if (r < 18) begin
            it.op = OP_RESTART;
        end else if (r < 20) begin
            it.op = OP_NONE;
        end
        return it;
    endfunction

    task automatic send_item(search_item_t it);
        search_status_t s;
        while (!quiet && $urandom_range(0, 99) < 21) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        operation <= it.op;
        node_index <= it.idx;
        node_kind <= it.kind;
        node_char <= it.chr;
        node_successor <= it.succ;
        node_alternative <= it.alt;
        text_char <= it.tch;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        s = search_step(it);
        if (it.typed) begin
            s.mf = it.e_mf;
            s.es = it.e_es;
            s.cp = it.e_cp;
        end
        status_q.push_back(s);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (status_q.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_start(logic [31:0] v);
        cfg_valid <= 1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        start_reg = v;
    endtask

    // Result checker and receiver stall.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (status_q.size() == 0) begin
                    $display("%0t: unexpected result %0d %h %h", $time,
                             match_found, earliest_start, current_position);
                    errors++;
                end else begin
                    search_status_t e;
                    e = status_q.pop_front();
                    if (match_found !== e.mf) begin
                        $display("%0t: match_found expected %0d actual %0d", $time,
                                 e.mf, match_found);
                        errors++;
                    end
                    if (earliest_start !== e.es) begin
                        $display("%0t: earliest_start expected %h actual %h", $time,
                                 e.es, earliest_start);
                        errors++;
                    end
                    if (current_position !== e.cp) begin
                        $display("%0t: current_position expected %h actual %h", $time,
                                 e.cp, current_position);
                        errors++;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 21);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        search_item_t dir_tab[$];
        logic [31:0] starts[6];
        rst_n = 0;
        cfg_valid = 0;
        cfg_data = 0;
        in_valid = 0;
        operation = OP_NONE;
        node_index = 0;
        node_kind = 0;
        node_char = 0;
        node_successor = 0;
        node_alternative = 0;
        text_char = 0;
        out_stall = 0;
        for (int i = 0; i < N_NODES; i++) begin
            ntab[i] = '{0, 0, 0, 0};
            written[i] = 0;
        end
        clear_sets();
        pos = 0;
        start_reg = 0;

        dir_tab.push_back(typed_row(row(OP_LOAD, 0, 0, 8'h61, 1, 32, 0), 0, 0, 0));
        dir_tab.push_back(typed_row(row(OP_LOAD, 1, 1, 8'hff, 63, 63, 0), 0, 0, 0));
        dir_tab.push_back(typed_row(row(OP_NONE, 31, 1, 8'hff, 63, 63, 8'hff), 0, 0, 0));
        dir_tab.push_back(typed_row(row(OP_RESTART, 0, 0, 0, 0, 0, 0), 0, 0, 32'hffff_fffe));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h62));
        // The match starts just before the position wraps to zero.
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h61));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h00));
        dir_tab.push_back(row(OP_LOAD, 2, 0, 8'hff, 1, 32, 0));
        dir_tab.push_back(row(OP_LOAD, 0, 0, 8'h61, 1, 2, 0));
        dir_tab.push_back(row(OP_RESTART, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'hff));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h61));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'hff));
        // A success node in the start chain matches at once.
        dir_tab.push_back(row(OP_LOAD, 3, 1, 8'h00, 32, 32, 0));
        dir_tab.push_back(row(OP_LOAD, 0, 0, 8'h61, 32, 3, 0));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h55));
        dir_tab.push_back(row(OP_RESTART, 0, 0, 0, 0, 0, 0));
        // Self-linked node: the walk is cut off after a full table of steps.
        dir_tab.push_back(row(OP_LOAD, 4, 0, 8'h61, 4, 4, 0));
        dir_tab.push_back(row(OP_LOAD, 0, 0, 8'h61, 1, 4, 0));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h61));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h61));
        dir_tab.push_back(row(OP_FEED, 0, 0, 0, 0, 0, 8'h62));

        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        write_start(32'hffff_fffe);
        foreach (dir_tab[i]) send_item(dir_tab[i]);
        drain();

        starts = '{32'd0, 32'hffff_ffff, $urandom, 32'hffff_fff0, 32'd1, $urandom};
        for (int ph = 0; ph < 6; ph++) begin
            write_start(starts[ph]);
            quiet = (ph == 3);
            send_item(row(OP_RESTART, 0, 0, 0, 0, 0, 0));
            for (int n = 0; n < 280; n++) begin
                // Let the output back up while the next item waits at the input.
                if (ph == 1 && n == 20) hold_cnt = 3000;
                send_item(random_item());
            end
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
